// ----- sv/trle_pkg.sv -----
// ----------------------------------------------------------------------------
// trle_pkg
// shared types, constants and helpers for the tga run-length pixel decoder
// ----------------------------------------------------------------------------
package trle_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned PixelW  = 32;
  localparam int unsigned RepeatW = 8;
  localparam int unsigned BppW    = 3;
  localparam int unsigned IndexW  = 2;

  localparam logic [BppW-1:0]  BppReset  = 3'd4;
  localparam logic [BppW-1:0]  BppMin    = 3'd1;
  localparam logic [BppW-1:0]  BppMax    = 3'd4;
  localparam logic [ByteW-1:0] CountMask = 8'h7f;
  localparam int unsigned      RunBit    = 7;

  // one decoded pixel leaving the core
  typedef struct packed {
    logic               emit;
    logic [PixelW-1:0]  pixel;
    logic [RepeatW-1:0] rpt;
  } trle_res_t;

  // out-of-range settings: zero acts as one, five to seven act as four
  function automatic logic [BppW-1:0] eff_bpp(input logic [BppW-1:0] bpp);
    logic [BppW-1:0] b;
    b = bpp;
    if (bpp == '0) begin
      b = BppMin;
    end else if (bpp > BppMax) begin
      b = BppMax;
    end
    return b;
  endfunction

endpackage

// ----- sv/trle_core.sv -----
// ----------------------------------------------------------------------------
// trle_core
// packet state, byte gathering and pixel emission for one byte per step
// ----------------------------------------------------------------------------
module trle_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  logic [trle_pkg::ByteW-1:0]    data_byte,
  input  logic [trle_pkg::BppW-1:0]     bpp,
  output trle_pkg::trle_res_t           res
);
  import trle_pkg::*;

  logic [RepeatW-1:0] pixels_left_r, pixels_left_nxt;
  logic               run_packet_r, run_packet_nxt;
  logic [IndexW-1:0]  byte_index_r, byte_index_nxt;
  logic [PixelW-1:0]  acc_r, acc_nxt;

  logic [PixelW-1:0]  acc_shift;
  logic [BppW-1:0]    gathered;
  logic               is_header;
  logic               done;

  assign is_header = (pixels_left_r == '0);
  assign acc_shift = {acc_r[PixelW-ByteW-1:0], data_byte};
  assign gathered  = {1'b0, byte_index_r} + BppW'(1);
  assign done      = (gathered >= eff_bpp(bpp));

  always_comb begin
    pixels_left_nxt = pixels_left_r;
    run_packet_nxt  = run_packet_r;
    byte_index_nxt  = byte_index_r;
    acc_nxt         = acc_r;
    res.emit        = 1'b0;
    res.pixel       = acc_shift;
    res.rpt         = run_packet_r ? pixels_left_r : RepeatW'(1);
    if (is_header) begin
      // count field plus one, run flag in the top bit
      pixels_left_nxt = (data_byte & CountMask) + RepeatW'(1);
      run_packet_nxt  = data_byte[RunBit];
      byte_index_nxt  = '0;
      acc_nxt         = '0;
    end else if (!done) begin
      acc_nxt        = acc_shift;
      byte_index_nxt = gathered[IndexW-1:0];
    end else begin
      res.emit        = 1'b1;
      pixels_left_nxt = run_packet_r ? '0 : pixels_left_r - RepeatW'(1);
      byte_index_nxt  = '0;
      acc_nxt         = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixels_left_r <= '0;
      run_packet_r  <= 1'b0;
      byte_index_r  <= '0;
      acc_r         <= '0;
    end else if (step) begin
      pixels_left_r <= pixels_left_nxt;
      run_packet_r  <= run_packet_nxt;
      byte_index_r  <= byte_index_nxt;
      acc_r         <= acc_nxt;
    end
  end

endmodule

// ----- sv/tga_rle_pixel_decoder.sv -----
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder
// run-length decoder for tga pixel streams, one byte in, at most one pixel out
// ----------------------------------------------------------------------------
// One compressed byte is taken per transfer on the input channel, and the
// block sustains one byte per clock cycle while the output register does not
// stall. Each byte is first held in an input register, then logic updates
// the packet state and, when a pixel is complete, loads the output register;
// a completing byte's result passes from the input register to the output
// register, from which it can leave. Header bytes and bytes that do
// not finish a pixel give no result. A run packet yields a single result with
// out_repeat_count set to the packet length; a raw packet yields one result
// per pixel with a repeat count of one. The first byte of a pixel lands in
// the most significant position, and narrow pixels carry zero above. The
// bytes-per-pixel setting (reset 4, zero read as 1, above 4 read as 4) is
// written through cfg_wr_en/cfg_wr_data and should only change while the
// block is idle. The only stall source is the output register: a new byte
// moves forward whenever the output register is empty or is being drained.
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_wr_en,
  input  logic [trle_pkg::BppW-1:0]     cfg_wr_data,
  // compressed byte input
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [trle_pkg::ByteW-1:0]    in_data_byte,
  // decoded pixel output
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [trle_pkg::PixelW-1:0]   out_pixel_value,
  output logic [trle_pkg::RepeatW-1:0]  out_repeat_count
);
  import trle_pkg::*;

  // configuration register
  logic [BppW-1:0]    bpp_r;

  // input stage
  logic               s1_valid_r, s1_valid_nxt;
  logic [ByteW-1:0]   s1_byte_r;

  // output stage
  logic               out_valid_r, out_valid_nxt;
  logic [PixelW-1:0]  out_pixel_r;
  logic [RepeatW-1:0] out_rpt_r;

  trle_res_t          res;
  logic               advance;

  // the held byte is consumed when the output register has room for a result
  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpp_r <= BppReset;
    end else if (cfg_wr_en) begin
      bpp_r <= cfg_wr_data;
    end
  end

  // input register: refill on a transfer, empty when the byte moves on
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_valid && in_ready) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_data_byte;
    end
  end

  // packet state and byte gathering
  trle_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .data_byte (s1_byte_r),
    .bpp       (bpp_r),
    .res       (res)
  );

  // output register: loaded with a new pixel, cleared once drained
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = res.emit;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.emit) begin
      out_pixel_r <= res.pixel;
      out_rpt_r   <= res.rpt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_value  = out_pixel_r;
  assign out_repeat_count = out_rpt_r;

endmodule
